/* rtl/lzpmd_pkg.sv */
package lzpmd_pkg;

   // sizes
   localparam int BLOCK_ADDR_BITS = 20;
   localparam int HASH_MAX_BITS   = 16;
   localparam int POS_BITS        = BLOCK_ADDR_BITS + 1;
   localparam int LEN_BITS        = 21;
   localparam int EPOCH_BITS      = 8;
   localparam int HIST_DEPTH      = 1 << BLOCK_ADDR_BITS;
   localparam int TBL_DEPTH       = 1 << HASH_MAX_BITS;
   localparam int CSR_ADDR_BITS   = 3;
   localparam int CSR_DATA_BITS   = 32;

   // decoder constants
   localparam logic [7:0]          MARKER    = 8'hF2;
   localparam logic [7:0]          LEN_MORE  = 8'd254;
   localparam logic [7:0]          MARK_ESC  = 8'd255;
   localparam logic [LEN_BITS-1:0] LEN_MAX   = '1;
   localparam int                  HDR_BYTES = 4;
   localparam int                  HB_MIN    = 8;
   localparam logic [7:0]          MM_MIN    = 8'd4;
   localparam logic [4:0]          HB_RESET  = 5'd16;
   localparam logic [7:0]          MM_RESET  = 8'd40;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_TOKEN,
      PH_MARK,
      PH_LEN,
      PH_COPY,
      PH_DRAIN
   } phase_type;

   typedef enum logic [2:0] {
      ST_OK,
      ST_BUSY,
      ST_SHORT,
      ST_TRUNC,
      ST_OVERFLOW
   } status_type;

   typedef enum logic {
      CMD_BYTE,
      CMD_TICK
   } cmd_type;

   typedef enum logic {
      REG_HASH_BITS,
      REG_MIN_MATCH
   } reg_type;

   typedef struct packed {
      logic [4:0] hash_bits;
      logic [7:0] min_match;
   } cfg_type;

   typedef struct packed {
      logic [EPOCH_BITS-1:0]      epoch;
      logic [BLOCK_ADDR_BITS-1:0] value;
   } ptab_entry_type;

   typedef struct packed {
      logic [HASH_MAX_BITS-1:0]   raddr;
      logic                       we;
      logic [HASH_MAX_BITS-1:0]   waddr;
      logic [BLOCK_ADDR_BITS-1:0] wdata;
      logic                       block_end;
   } ptab_req_type;

   typedef struct packed {
      logic                       busy;
      logic [BLOCK_ADDR_BITS-1:0] value;
   } ptab_rsp_type;

   // context hash, masked to the clamped table size
   function automatic logic [HASH_MAX_BITS-1:0] hash_index(input logic [31:0] ctx,
                                                           input logic [4:0]  hb);
      logic [31:0]              mix;
      logic [HASH_MAX_BITS-1:0] mask;
      int unsigned              width;
      mix   = (ctx >> 15) ^ ctx ^ (ctx >> 3);
      width = int'(hb);
      if (width < HB_MIN) width = HB_MIN;
      if (width > HASH_MAX_BITS) width = HASH_MAX_BITS;
      for (int i = 0; i < HASH_MAX_BITS; i++) begin
         mask[i] = (i < width);
      end
      return mix[HASH_MAX_BITS-1:0] & mask;
   endfunction

   function automatic logic [7:0] min_match_eff(input logic [7:0] mm);
      return (mm < MM_MIN) ? MM_MIN : mm;
   endfunction

endpackage

/* rtl/lzpmd_ram.sv */
module lzpmd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int ADDR_BITS = $clog2(DEPTH)
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [WIDTH-1:0]     wdata,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [WIDTH-1:0]     rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // read-first on a same-address collision
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/lzpmd_csr.sv */
module lzpmd_csr import lzpmd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output cfg_type                  cfg_cur,
   output cfg_type                  cfg_nxt
);

   cfg_type cfg_ff, cfg_in;
   reg_type reg_sel;
   logic    wr;

   assign csr_pready = 1'b1;
   assign reg_sel    = reg_type'(csr_paddr[2]);
   assign wr         = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr) begin
         unique case (reg_sel)
            REG_HASH_BITS: cfg_in.hash_bits = csr_pwdata[4:0];
            REG_MIN_MATCH: cfg_in.min_match = csr_pwdata[7:0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_HASH_BITS: csr_prdata = CSR_DATA_BITS'(cfg_ff.hash_bits);
         REG_MIN_MATCH: csr_prdata = CSR_DATA_BITS'(cfg_ff.min_match);
         default:       csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hash_bits <= HB_RESET;
         cfg_ff.min_match <= MM_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg_cur = cfg_ff;
   assign cfg_nxt = cfg_in;

endmodule

/* rtl/lzpmd_ptab.sv */
module lzpmd_ptab import lzpmd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  ptab_req_type req,
   output ptab_rsp_type rsp
);

   logic [EPOCH_BITS-1:0]    epoch_ff, epoch_in;
   logic                     clr_active_ff, clr_active_in;
   logic [HASH_MAX_BITS-1:0] clr_addr_ff, clr_addr_in;
   logic                     fwd_hit_ff, fwd_hit_in;
   ptab_entry_type           fwd_ff;

   logic                     we;
   logic [HASH_MAX_BITS-1:0] waddr;
   ptab_entry_type           wdata;
   ptab_entry_type           rdata;
   ptab_entry_type           word;

   // clearing pass owns the write port while it runs
   always_comb begin
      we    = clr_active_ff || req.we;
      waddr = clr_active_ff ? clr_addr_ff : req.waddr;
      if (clr_active_ff) begin
         wdata = '0;
      end else begin
         wdata.epoch = epoch_ff;
         wdata.value = req.wdata;
      end
   end

   lzpmd_ram #(
      .WIDTH ($bits(ptab_entry_type)),
      .DEPTH (TBL_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (req.raddr),
      .rdata (rdata)
   );

   // a block end retires every entry by moving the epoch; on wrap, old marks
   // could alias, so the table is swept back to zero
   always_comb begin
      epoch_in      = epoch_ff;
      clr_active_in = clr_active_ff;
      clr_addr_in   = clr_addr_ff;
      if (clr_active_ff) begin
         clr_addr_in = clr_addr_ff + HASH_MAX_BITS'(1);
         if (clr_addr_ff == '1) begin
            clr_active_in = 1'b0;
         end
      end
      if (req.block_end) begin
         epoch_in = epoch_ff + EPOCH_BITS'(1);
         if (epoch_ff == '1) begin
            clr_active_in = 1'b1;
            clr_addr_in   = '0;
         end
      end
   end

   assign fwd_hit_in = we && (waddr == req.raddr);

   always_ff @(posedge clock) begin
      if (reset) begin
         epoch_ff      <= '0;
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         fwd_hit_ff    <= 1'b0;
      end else begin
         epoch_ff      <= epoch_in;
         clr_active_ff <= clr_active_in;
         clr_addr_ff   <= clr_addr_in;
         fwd_hit_ff    <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      fwd_ff <= wdata;
   end

   assign word      = fwd_hit_ff ? fwd_ff : rdata;
   assign rsp.value = (word.epoch == epoch_ff) ? word.value : '0;
   assign rsp.busy  = clr_active_ff;

endmodule

/* rtl/lzpmd_core.sv */
module lzpmd_core import lzpmd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,
   input  logic         req_tuser,
   input  logic         req_tlast,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [15:0]  rsp_tdata,
   output logic [3:0]   rsp_tuser,
   output logic         rsp_tlast,
   input  cfg_type      cfg_cur,
   input  cfg_type      cfg_nxt,
   input  ptab_rsp_type ptab_rsp,
   output ptab_req_type ptab_req
);

   phase_type                  phase_ff, phase_in;
   logic [31:0]                ctx_ff, ctx_in;
   logic [POS_BITS-1:0]        pos_ff, pos_in;
   logic [BLOCK_ADDR_BITS-1:0] src_ff, src_in;
   logic [LEN_BITS-1:0]        lsum_ff, lsum_in;
   logic [LEN_BITS-1:0]        left_ff, left_in;
   logic                       endp_ff, endp_in;

   logic                       ovalid_ff, ovalid_in;
   logic                       obv_ff;
   logic [7:0]                 obyte_ff;
   logic                       orun_ff;
   logic                       oend_ff;
   status_type                 ostat_ff;

   logic                       hfwd_ff, hfwd_in;
   logic [7:0]                 hfwd_data_ff;
   logic [7:0]                 hist_rdata;
   logic [7:0]                 hist_byte;

   logic                       acc, is_tick, full, hit, marker_hit, is_more, last_copy;
   logic [7:0]                 b, lit_byte, mm;
   logic [LEN_BITS-1:0]        len_base;
   logic [LEN_BITS:0]          len_sum;
   logic [LEN_BITS-1:0]        len_new;

   logic                       emit, bv, run, be, put, lit, len_take;
   logic [7:0]                 obyte, pbyte;
   status_type                 st;
   logic                       tbl_we, end_blk;
   logic                       src_load, src_step, left_step, len_load, left_load;

   assign req_tready = (!ovalid_ff || rsp_tready) && !ptab_rsp.busy;
   assign acc        = req_tvalid && req_tready;
   assign is_tick    = cmd_type'(req_tuser) == CMD_TICK;
   assign b          = req_tdata;
   assign full       = pos_ff[BLOCK_ADDR_BITS];
   assign hit        = ptab_rsp.value != '0;
   assign marker_hit = (b == MARKER) && hit;
   assign is_more    = b == LEN_MORE;
   assign last_copy  = left_ff == LEN_BITS'(1);
   assign lit_byte   = (phase_ff == PH_MARK) ? MARKER : b;
   assign mm         = min_match_eff(cfg_cur.min_match);

   // length sum saturates; the first length byte starts from min_match
   assign len_base = (phase_ff == PH_MARK) ? LEN_BITS'(mm) : lsum_ff;
   assign len_sum  = {1'b0, len_base} + (LEN_BITS + 1)'(b);
   assign len_new  = len_sum[LEN_BITS] ? LEN_MAX : len_sum[LEN_BITS-1:0];

   // history read data, with the byte written in the same cycle forwarded
   assign hist_byte = hfwd_ff ? hfwd_data_ff : hist_rdata;

   // item decode and result
   always_comb begin
      emit      = 1'b0;
      bv        = 1'b0;
      obyte     = '0;
      run       = 1'b0;
      be        = 1'b0;
      st        = ST_OK;
      put       = 1'b0;
      pbyte     = b;
      lit       = 1'b0;
      len_take  = 1'b0;
      tbl_we    = 1'b0;
      end_blk   = 1'b0;
      src_load  = 1'b0;
      src_step  = 1'b0;
      left_step = 1'b0;
      len_load  = 1'b0;
      left_load = 1'b0;
      if (acc) begin
         if (is_tick) begin
            if (phase_ff == PH_COPY) begin
               emit = 1'b1;
               if (full) begin
                  st      = ST_OVERFLOW;
                  be      = endp_ff;
                  end_blk = endp_ff;
               end else begin
                  bv        = 1'b1;
                  obyte     = hist_byte;
                  put       = 1'b1;
                  pbyte     = hist_byte;
                  src_step  = 1'b1;
                  left_step = 1'b1;
                  run       = last_copy;
                  if (last_copy && endp_ff) begin
                     be      = 1'b1;
                     end_blk = 1'b1;
                  end
               end
            end
         end else begin
            unique case (phase_ff)
               PH_COPY: begin
                  emit = 1'b1;
                  st   = ST_BUSY;
               end
               PH_DRAIN: begin
                  if (req_tlast) begin
                     emit    = 1'b1;
                     st      = ST_OVERFLOW;
                     be      = 1'b1;
                     end_blk = 1'b1;
                  end
               end
               PH_HEADER: begin
                  emit    = 1'b1;
                  be      = req_tlast;
                  end_blk = req_tlast;
                  if (req_tlast && (pos_ff < POS_BITS'(HDR_BYTES - 1))) begin
                     st = ST_SHORT;
                  end else begin
                     bv    = 1'b1;
                     obyte = b;
                     put   = 1'b1;
                  end
               end
               PH_TOKEN: begin
                  tbl_we = 1'b1;
                  if (marker_hit) begin
                     src_load = 1'b1;
                     if (req_tlast) begin
                        emit    = 1'b1;
                        st      = ST_TRUNC;
                        be      = 1'b1;
                        end_blk = 1'b1;
                     end
                  end else begin
                     lit = 1'b1;
                  end
               end
               PH_MARK: begin
                  if (b == MARK_ESC) begin
                     lit = 1'b1;
                  end else begin
                     len_take = 1'b1;
                  end
               end
               PH_LEN: begin
                  len_take = 1'b1;
               end
               default: begin
                  end_blk = 1'b1;
               end
            endcase
            if (lit) begin
               emit    = 1'b1;
               be      = req_tlast;
               end_blk = req_tlast;
               if (full) begin
                  st = ST_OVERFLOW;
               end else begin
                  bv    = 1'b1;
                  obyte = lit_byte;
                  put   = 1'b1;
                  pbyte = lit_byte;
               end
            end
            if (len_take) begin
               len_load = 1'b1;
               if (is_more) begin
                  if (req_tlast) begin
                     emit    = 1'b1;
                     st      = ST_TRUNC;
                     be      = 1'b1;
                     end_blk = 1'b1;
                  end
               end else begin
                  left_load = 1'b1;
               end
            end
         end
      end
   end

   // phase sequencing
   always_comb begin
      phase_in = phase_ff;
      if (end_blk) begin
         phase_in = PH_HEADER;
      end else if (acc) begin
         unique case (phase_ff)
            PH_HEADER: begin
               if (!is_tick && (pos_ff == POS_BITS'(HDR_BYTES - 1))) begin
                  phase_in = PH_TOKEN;
               end
            end
            PH_TOKEN: begin
               if (!is_tick) begin
                  if (marker_hit) begin
                     phase_in = PH_MARK;
                  end else if (full) begin
                     phase_in = PH_DRAIN;
                  end
               end
            end
            PH_MARK: begin
               if (!is_tick) begin
                  if (b == MARK_ESC) begin
                     phase_in = full ? PH_DRAIN : PH_TOKEN;
                  end else begin
                     phase_in = is_more ? PH_LEN : PH_COPY;
                  end
               end
            end
            PH_LEN: begin
               if (!is_tick) begin
                  phase_in = is_more ? PH_LEN : PH_COPY;
               end
            end
            PH_COPY: begin
               if (is_tick) begin
                  if (full) begin
                     phase_in = PH_DRAIN;
                  end else if (last_copy) begin
                     phase_in = PH_TOKEN;
                  end
               end
            end
            PH_DRAIN: begin
               phase_in = PH_DRAIN;
            end
            default: begin
               phase_in = PH_HEADER;
            end
         endcase
      end
   end

   // datapath next values; a block end wins over everything else
   always_comb begin
      if (end_blk) begin
         ctx_in  = '0;
         pos_in  = '0;
         src_in  = '0;
         lsum_in = '0;
         left_in = '0;
         endp_in = 1'b0;
      end else begin
         ctx_in  = put ? {ctx_ff[23:0], pbyte} : ctx_ff;
         pos_in  = put ? pos_ff + POS_BITS'(1) : pos_ff;
         src_in  = src_load ? ptab_rsp.value :
                   src_step ? src_ff + BLOCK_ADDR_BITS'(1) : src_ff;
         lsum_in = len_load ? len_new : lsum_ff;
         left_in = left_load ? len_new :
                   left_step ? left_ff - LEN_BITS'(1) : left_ff;
         endp_in = left_load ? req_tlast : endp_ff;
      end
   end

   // position table: read ahead on the next context, write on the current one
   always_comb begin
      ptab_req.raddr     = hash_index(ctx_in, cfg_nxt.hash_bits);
      ptab_req.we        = tbl_we;
      ptab_req.waddr     = hash_index(ctx_ff, cfg_cur.hash_bits);
      ptab_req.wdata     = pos_ff[BLOCK_ADDR_BITS-1:0];
      ptab_req.block_end = end_blk;
   end

   // history: write at the output position, read ahead at the next source
   lzpmd_ram #(
      .WIDTH (8),
      .DEPTH (HIST_DEPTH)
   ) u_hist (
      .clock (clock),
      .we    (put),
      .waddr (pos_ff[BLOCK_ADDR_BITS-1:0]),
      .wdata (pbyte),
      .raddr (src_in),
      .rdata (hist_rdata)
   );

   assign hfwd_in   = put && (pos_ff[BLOCK_ADDR_BITS-1:0] == src_in);
   assign ovalid_in = emit ? 1'b1 : (rsp_tready ? 1'b0 : ovalid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEADER;
         ctx_ff    <= '0;
         pos_ff    <= '0;
         src_ff    <= '0;
         lsum_ff   <= '0;
         left_ff   <= '0;
         endp_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
         hfwd_ff   <= 1'b0;
      end else begin
         phase_ff  <= phase_in;
         ctx_ff    <= ctx_in;
         pos_ff    <= pos_in;
         src_ff    <= src_in;
         lsum_ff   <= lsum_in;
         left_ff   <= left_in;
         endp_ff   <= endp_in;
         ovalid_ff <= ovalid_in;
         hfwd_ff   <= hfwd_in;
      end
   end

   always_ff @(posedge clock) begin
      hfwd_data_ff <= pbyte;
      if (emit) begin
         obv_ff   <= bv;
         obyte_ff <= obyte;
         orun_ff  <= run;
         oend_ff  <= be;
         ostat_ff <= st;
      end
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tdata  = {7'b0, orun_ff, obyte_ff};
   assign rsp_tuser  = {ostat_ff, obv_ff};
   assign rsp_tlast  = oend_ff;

endmodule

/* rtl/lzp_match_decoder_unit.sv */
// LZP block decoder. Each input item is either a compressed byte or a tick
// (req_tuser high) that copies one byte of a pending match from history.
// One item is taken per clock cycle; its result, if any, shows on the
// rsp side in the following cycle from an output register. req_tready
// drops while that register holds a result that rsp_tready refuses, and
// during the position table clearing pass described below.
// Each token byte does one read-modify-write of the position table, and each
// item does at most one write and one read of the history memory; both
// memories read ahead on the next context and next copy source, with
// same-entry writes forwarded, so back-to-back items need no bubbles. The
// position table (65536 x 28 bits) is tagged with an 8-bit block epoch
// instead of being cleared per block; after reset, and after every 256th
// block end, a clearing pass sweeps it and req_tready stays low
// meanwhile (configuration writes are still taken). History is a
// 1048576 x 8 memory with no reset. Registers: hash_bits at byte address
// 0, min_match at byte address 4; write them only with the block idle.
module lzp_match_decoder_unit import lzpmd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   // input items
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,    // [7:0] data_byte
   input  logic                     req_tuser,    // [0] cmd
   input  logic                     req_tlast,    // last_in_block
   // results
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [15:0]              rsp_tdata,    // [7:0] out_byte, [8] run_end
   output logic [3:0]               rsp_tuser,    // [0] byte_valid, [3:1] status
   output logic                     rsp_tlast,    // block_end
   // configuration
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   cfg_type      cfg_cur;
   cfg_type      cfg_nxt;
   ptab_req_type ptab_req;
   ptab_rsp_type ptab_rsp;

   lzpmd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg_cur     (cfg_cur),
      .cfg_nxt     (cfg_nxt)
   );

   // position table with epoch tags and clearing pass
   lzpmd_ptab u_ptab (
      .clock (clock),
      .reset (reset),
      .req   (ptab_req),
      .rsp   (ptab_rsp)
   );

   // token decode, history and output register
   lzpmd_core u_core (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .cfg_cur    (cfg_cur),
      .cfg_nxt    (cfg_nxt),
      .ptab_rsp   (ptab_rsp),
      .ptab_req   (ptab_req)
   );

endmodule

/* rtl/lzpmd_checker.sv */
module lzpmd_checker import lzpmd_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
      $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // table sweep after reset keeps the input closed
   a_reset_closed: assert property (@(posedge clock)
      reset |=> !req_tready)
      else $error("input open straight after reset");

   // no new item while the output register is full and refused
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("item taken over a pending result");

   // an error result carries no byte
   a_err_no_byte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser[3:1] != ST_OK) |-> !rsp_tuser[0] && (rsp_tdata[7:0] == 8'd0))
      else $error("error result with byte");

   // run end only on a good copied byte
   a_run_end: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[8] |-> rsp_tuser[0] && (rsp_tuser[3:1] == ST_OK))
      else $error("run end without byte");

endmodule

bind lzp_match_decoder_unit lzpmd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

/* tb/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
   import lzpmd_pkg::*;

   logic                     clock;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata   = '0;   // [7:0] data_byte
   logic                     req_tuser   = 1'b0; // [0] cmd
   logic                     req_tlast   = 1'b0; // last_in_block
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [15:0]              rsp_tdata;          // [7:0] out_byte, [8] run_end
   logic [3:0]               rsp_tuser;          // [0] byte_valid, [3:1] status
   logic                     rsp_tlast;          // block_end
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   lzp_match_decoder_unit dut (.*);

   typedef struct packed {
      logic       byte_valid;
      logic [7:0] out_byte;
      logic       run_end;
      logic       block_end;
      status_type status;
   } dec_result_type;

   // Decoder state tracked item by item, plus the decoded results still due
   class decode_tracker;
      bit [7:0]    hist [HIST_DEPTH];
      int unsigned ptab [int unsigned];   // absent entry reads as zero
      bit [31:0]   ctx;
      int unsigned opos, src, lsum, left;
      phase_type   ph;
      bit          end_due;
      bit [4:0]    hb;
      bit [7:0]    mm;
      dec_result_type outs_due [$];
      int          faults;

      function new();
         hb = HB_RESET;
         mm = MM_RESET;
         restart();
      endfunction

      function void set_reg(reg_type r, logic [31:0] v);
         if (r == REG_HASH_BITS) hb = v[4:0];
         else mm = v[7:0];
      endfunction

      function void restart();
         ptab.delete();
         ctx     = '0;
         opos    = 0;
         ph      = PH_HEADER;
         src     = 0;
         lsum    = 0;
         left    = 0;
         end_due = 1'b0;
      endfunction

      function void due_push(bit v, bit [7:0] b, bit run, bit be, status_type st);
         dec_result_type e;
         e.byte_valid = v;
         e.out_byte   = v ? b : 8'h00;
         e.run_end    = run;
         e.block_end  = be;
         e.status     = st;
         outs_due.push_back(e);
      endfunction

      function void push_byte(bit [7:0] b);
         hist[opos % HIST_DEPTH] = b;
         opos++;
         ctx = {ctx[23:0], b};
      endfunction

      // out of history space: end now, or swallow items up to the block end
      function void fault(bit ends);
         if (ends) begin
            restart();
            due_push(1'b0, 8'h00, 1'b0, 1'b1, ST_OVERFLOW);
         end else begin
            ph = PH_DRAIN;
            due_push(1'b0, 8'h00, 1'b0, 1'b0, ST_OVERFLOW);
         end
      endfunction

      function void emit_plain(bit [7:0] b, bit l);
         if (opos >= HIST_DEPTH) begin
            fault(l);
            return;
         end
         push_byte(b);
         ph = PH_TOKEN;
         if (l) restart();
         due_push(1'b1, b, 1'b0, l, ST_OK);
      endfunction

      // a length byte of 254 asks for another one
      function void close_length(bit [7:0] b, bit l);
         if (b == LEN_MORE) begin
            ph = PH_LEN;
            if (l) begin
               restart();
               due_push(1'b0, 8'h00, 1'b0, 1'b1, ST_TRUNC);
            end
         end else begin
            left    = lsum;
            end_due = l;
            ph      = PH_COPY;
         end
      endfunction

      function void take_item(cmd_type c, bit [7:0] b, bit l);
         bit [7:0]    v;
         bit          run, be;
         bit [31:0]   mix;
         int          w;
         int unsigned idx, old;
         if (c == CMD_TICK) begin
            if (ph != PH_COPY) return;
            if (opos >= HIST_DEPTH) begin
               fault(end_due);
               return;
            end
            v = hist[src % HIST_DEPTH];
            src++;
            push_byte(v);
            left--;
            run = (left == 0);
            be  = 1'b0;
            if (run) begin
               if (end_due) begin
                  be = 1'b1;
                  restart();
               end else begin
                  ph = PH_TOKEN;
               end
            end
            due_push(1'b1, v, run, be, ST_OK);
            return;
         end
         case (ph)
            PH_COPY: due_push(1'b0, 8'h00, 1'b0, 1'b0, ST_BUSY);
            PH_DRAIN: begin
               if (l) begin
                  restart();
                  due_push(1'b0, 8'h00, 1'b0, 1'b1, ST_OVERFLOW);
               end
            end
            PH_HEADER: begin
               if (l && opos < 3) begin
                  restart();
                  due_push(1'b0, 8'h00, 1'b0, 1'b1, ST_SHORT);
               end else begin
                  push_byte(b);
                  if (opos >= HDR_BYTES) ph = PH_TOKEN;
                  if (l) restart();
                  due_push(1'b1, b, 1'b0, l, ST_OK);
               end
            end
            PH_TOKEN: begin
               mix = (ctx >> 15) ^ ctx ^ (ctx >> 3);
               w   = hb;
               if (w < HB_MIN) w = HB_MIN;
               if (w > HASH_MAX_BITS) w = HASH_MAX_BITS;
               idx = mix & ((32'd1 << w) - 1);
               old = ptab.exists(idx) ? ptab[idx] : 0;
               ptab[idx] = opos;
               if (b == MARKER && old > 0) begin
                  src = old;
                  ph  = PH_MARK;
                  if (l) begin
                     restart();
                     due_push(1'b0, 8'h00, 1'b0, 1'b1, ST_TRUNC);
                  end
               end else begin
                  emit_plain(b, l);
               end
            end
            PH_MARK: begin
               if (b == MARK_ESC) begin
                  emit_plain(MARKER, l);
               end else begin
                  lsum = ((mm < MM_MIN) ? MM_MIN : mm) + b;
                  close_length(b, l);
               end
            end
            PH_LEN: begin
               lsum += b;
               if (lsum > LEN_MAX) lsum = LEN_MAX;
               close_length(b, l);
            end
            default: restart();
         endcase
      endfunction

      function void check_output(logic [15:0] tdata, logic [3:0] tuser, logic tlast);
         dec_result_type got, want;
         got.byte_valid = tuser[0];
         got.out_byte   = tdata[7:0];
         got.run_end    = tdata[8];
         got.block_end  = tlast;
         got.status     = status_type'(tuser[3:1]);
         if (outs_due.size() == 0) begin
            faults++;
            if (faults <= 10)
               $display("%0t: result with none due: valid %0b byte %02h run %0b end %0b st %0d",
                        $realtime, got.byte_valid, got.out_byte, got.run_end,
                        got.block_end, got.status);
            return;
         end
         want = outs_due.pop_front();
         if (got !== want) begin
            faults++;
            if (faults <= 10) begin
               $display("%0t: mismatch: want valid %0b byte %02h run %0b end %0b st %0d",
                        $realtime, want.byte_valid, want.out_byte, want.run_end,
                        want.block_end, want.status);
               $display("   got valid %0b byte %02h run %0b end %0b st %0d",
                        got.byte_valid, got.out_byte, got.run_end, got.block_end,
                        got.status);
            end
         end
      endfunction
   endclass

   decode_tracker tracker = new();

   // idling odds in percent, changed per phase
   int       idle_pct  = 0;
   int       stall_pct = 0;
   bit       hold_ask  = 1'b0;
   int       hold_left = 0;

   // per-block stimulus shaping
   int       blk_items = 0;
   int       blk_goal  = 0;
   logic [7:0] theme   = 8'h00;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #4_000_000;
      $display("tb: failure");
      $finish;
   end

   // receiver: random back-pressure, plus one long hold-off on request
   always @(posedge clock) begin
      if (hold_ask) begin
         hold_ask  = 1'b0;
         hold_left = 300;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_output(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   // called just after a rising edge; returns after the access, with the bus released
   task automatic csr_write(input reg_type r, input logic [31:0] v);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(4 * int'(r));
      csr_pwdata  <= v;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_reg(r, v);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // offer one item, with random gaps first; returns at the accepting edge
   task automatic send(input cmd_type c, input logic [7:0] b, input logic l);
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= c;
      req_tdata  <= b;
      req_tlast  <= l;
      do @(posedge clock); while (!req_tready);
      tracker.take_item(c, b, l);
   endtask

   // wait for every due result, then let the pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (tracker.outs_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // Next item picked from the predicted phase: mostly well-formed tokens
   // with a repeated theme byte so contexts recur and markers find hits.
   task automatic next_item(output cmd_type c, output logic [7:0] b, output logic l);
      int r;
      if (tracker.ph == PH_HEADER && tracker.opos == 0) begin
         blk_items = 0;
         blk_goal  = $urandom_range(40, 6);
         theme     = 8'($urandom);
      end
      blk_items++;
      c = CMD_BYTE;
      b = 8'($urandom);
      l = 1'b0;
      r = $urandom_range(99);
      if (r < 8) begin
         // noise: anything at all
         c = cmd_type'($urandom_range(1));
         l = ($urandom_range(19) == 0);
         return;
      end
      r = $urandom_range(9);
      case (tracker.ph) inside
         PH_HEADER: begin
            if (r < 5) b = theme;
            l = ($urandom_range(24) == 0);
         end
         PH_TOKEN: begin
            if (r < 3) b = MARKER;
            else if (r < 7) b = theme;
            l = (blk_items >= blk_goal);
         end
         PH_MARK, PH_LEN: begin
            if (r < 2) b = (tracker.ph == PH_MARK) ? MARK_ESC : LEN_MORE;
            else if (r < 3) b = LEN_MORE;
            else if (r < 9) b = 8'($urandom_range(12));
            else b = 8'($urandom_range(255));
            l = (blk_items >= blk_goal);
         end
         PH_COPY: begin
            // now and then a byte that must be refused
            if (r != 0) c = CMD_TICK;
            l = 1'($urandom_range(1));
         end
         default: l = (blk_items >= blk_goal);
      endcase
   endtask

   task automatic random_items(input int n);
      cmd_type    c;
      logic [7:0] b;
      logic       l;
      for (int i = 0; i < n; i++) begin
         next_item(c, b, l);
         send(c, b, l);
      end
   endtask

   initial begin
      logic [31:0] hb_val, mm_val;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // below-range values, clamped to 8 table bits and a minimum match of 4
      csr_write(REG_HASH_BITS, 32'd0);
      csr_write(REG_MIN_MATCH, 32'd0);

      // short block: last flag on the second byte
      send(CMD_BYTE, 8'h00, 1'b0);
      send(CMD_BYTE, 8'hFF, 1'b1);
      // header, idle tick, literal, escaped marker, real match with a refused
      // byte mid-copy (its last flag dropped), then a marker cut off by last
      repeat (4) send(CMD_BYTE, 8'h41, 1'b0);
      send(CMD_TICK, 8'h00, 1'b0);
      send(CMD_BYTE, 8'h41, 1'b0);
      send(CMD_BYTE, MARKER, 1'b0);
      send(CMD_BYTE, MARK_ESC, 1'b0);
      repeat (4) send(CMD_BYTE, 8'h41, 1'b0);
      send(CMD_BYTE, MARKER, 1'b0);
      send(CMD_BYTE, 8'h00, 1'b0);
      send(CMD_BYTE, 8'h7E, 1'b1);
      repeat (4) send(CMD_TICK, 8'hFF, 1'b0);
      send(CMD_BYTE, MARKER, 1'b1);
      // block that ends on its fourth header byte
      send(CMD_BYTE, 8'h00, 1'b0);
      send(CMD_BYTE, 8'hFF, 1'b0);
      send(CMD_BYTE, 8'h80, 1'b0);
      send(CMD_BYTE, 8'h7F, 1'b1);
      settle();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin hb_val = 16; mm_val = 40;  idle_pct = 0;  stall_pct = 0;  end
            1: begin hb_val = 8;  mm_val = 255; idle_pct = 59; stall_pct = 0;  end
            2: begin hb_val = 12; mm_val = 3;   idle_pct = 0;  stall_pct = 59; end
            default: begin hb_val = 31; mm_val = 4; idle_pct = 31; stall_pct = 31; end
         endcase
         csr_write(REG_HASH_BITS, hb_val);
         csr_write(REG_MIN_MATCH, mm_val);
         random_items(120);
         // long receiver hold-off while items keep coming
         if (p == 0) hold_ask = 1'b1;
         // sender waits for everything due before going on
         if (p == 1) settle();
         random_items(130);
         settle();
      end

      if (tracker.faults == 0 && tracker.outs_due.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
